@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ rtl/core/psga_pkg.sv @@
package psga_pkg;

  // Default configuration of the group store and the command queue
  localparam int unsigned FLAG_VALUES_DEF   = 3;
  localparam int unsigned STATUS_VALUES_DEF = 2;
  localparam int unsigned FIFO_DEPTH_DEF    = 4;

  // Known code lists: three return flags, two line statuses
  localparam int unsigned FLAG_CODES_N   = 3;
  localparam int unsigned STATUS_CODES_N = 2;
  localparam logic [7:0] FLAG_CODES   [FLAG_CODES_N]   = '{8'h41, 8'h4E, 8'h52};
  localparam logic [7:0] STATUS_CODES [STATUS_CODES_N] = '{8'h46, 8'h4F};

  // At most three by two groups can ever match
  localparam int unsigned GRP_W = 3;
  localparam int unsigned SUM_W = 63;
  localparam int unsigned DP_W  = 31;
  localparam int unsigned CH_W  = 39;

  localparam logic [15:0]      CUTOFF_RESET = 16'd10471;
  localparam logic [6:0]       PCT          = 7'd100;
  localparam logic [SUM_W-1:0] SUM_MAX      = {SUM_W{1'b1}};

  typedef struct packed {
    logic [7:0]  return_flag;
    logic [7:0]  line_status;
    logic [15:0] ship_day;
    logic [15:0] quantity;
    logic [23:0] extended_price;
    logic [6:0]  discount;
    logic [6:0]  tax;
    logic        last_row;
  } row_t;

  typedef struct packed {
    logic [7:0]       group_flag;
    logic [7:0]       group_status;
    logic [SUM_W-1:0] total_quantity;
    logic [SUM_W-1:0] total_price;
    logic [SUM_W-1:0] total_discounted;
    logic [SUM_W-1:0] total_charge;
    logic [SUM_W-1:0] total_discount;
    logic [SUM_W-1:0] row_count;
    logic             final_group;
  } result_t;

  // Classified row handed from the front to the back
  typedef struct packed {
    logic             counted;
    logic             last;
    logic [GRP_W-1:0] grp;
    logic [15:0]      quantity;
    logic [23:0]      price;
    logic [DP_W-1:0]  discounted;
    logic [6:0]       discount;
    logic [6:0]       tax;
  } cmd_t;

  // One group accumulator
  typedef struct packed {
    logic [SUM_W-1:0] quantity;
    logic [SUM_W-1:0] price;
    logic [SUM_W-1:0] discounted;
    logic [SUM_W-1:0] charge;
    logic [SUM_W-1:0] discount;
    logic [SUM_W-1:0] count;
  } acc_t;

  // Saturating add; the stored sum never exceeds the top of its range
  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    logic [SUM_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return (sum >= {1'b0, SUM_MAX}) ? SUM_MAX : sum[SUM_W-1:0];
  endfunction

endpackage

@@ rtl/core/psga_front.sv @@
module psga_front #(
  parameter int unsigned FLAG_VALUES   = psga_pkg::FLAG_VALUES_DEF,
  parameter int unsigned STATUS_VALUES = psga_pkg::STATUS_VALUES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  psga_pkg::row_t  row_i,
  input  logic            push_i,
  input  logic            full_i,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i,
  output psga_pkg::cmd_t  cmd_o,
  output logic            cmd_push_o
);
  import psga_pkg::*;

  localparam int unsigned FLAG_USED =
    (FLAG_VALUES < FLAG_CODES_N) ? FLAG_VALUES : FLAG_CODES_N;
  localparam int unsigned STAT_USED =
    (STATUS_VALUES < STATUS_CODES_N) ? STATUS_VALUES : STATUS_CODES_N;

  logic [15:0] cutoff_q;
  logic [1:0]  fi;
  logic        si;
  logic        fhit;
  logic        shit;
  logic [6:0]  disc_c;

  // Hold the cutoff register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CUTOFF_RESET;
    end else if (cfg_we_i) begin
      cutoff_q <= cfg_wdata_i;
    end
  end

  // Look up the flag and status codes
  always_comb begin
    fi   = '0;
    si   = 1'b0;
    fhit = 1'b0;
    shit = 1'b0;
    for (int i = 0; i < FLAG_CODES_N; i++) begin
      if (i < FLAG_USED && row_i.return_flag == FLAG_CODES[i]) begin
        fi   = 2'(i);
        fhit = 1'b1;
      end
    end
    for (int j = 0; j < STATUS_CODES_N; j++) begin
      if (j < STAT_USED && row_i.line_status == STATUS_CODES[j]) begin
        si   = 1'(j);
        shit = 1'b1;
      end
    end
  end

  // Clamp the discount and form the discounted price
  assign disc_c = (row_i.discount > PCT) ? PCT : row_i.discount;

  always_comb begin
    cmd_o.counted    = fhit && shit && (row_i.ship_day <= cutoff_q);
    cmd_o.last       = row_i.last_row;
    cmd_o.grp        = GRP_W'(fi) * GRP_W'(STAT_USED) + GRP_W'(si);
    cmd_o.quantity   = row_i.quantity;
    cmd_o.price      = row_i.extended_price;
    cmd_o.discounted = {7'b0, row_i.extended_price} * {24'b0, PCT - disc_c};
    cmd_o.discount   = disc_c;
    cmd_o.tax        = row_i.tax;
  end

  // Queue only rows that count or that close the report
  assign cmd_push_o = push_i && !full_i && (cmd_o.counted || cmd_o.last);

endmodule

@@ rtl/core/psga_fifo.sv @@
module psga_fifo #(
  parameter int unsigned DEPTH = psga_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  psga_pkg::cmd_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output psga_pkg::cmd_t  data_o,
  output logic            empty_o
);
  import psga_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == (PTR_W+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Advance the pointers with wrap at the depth
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/psga_back.sv @@
module psga_back #(
  parameter int unsigned FLAG_VALUES   = psga_pkg::FLAG_VALUES_DEF,
  parameter int unsigned STATUS_VALUES = psga_pkg::STATUS_VALUES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psga_pkg::cmd_t    cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output psga_pkg::result_t result_o,
  output logic              empty_o,
  input  logic              pop_i
);
  import psga_pkg::*;

  localparam int unsigned FLAG_USED =
    (FLAG_VALUES < FLAG_CODES_N) ? FLAG_VALUES : FLAG_CODES_N;
  localparam int unsigned STAT_USED =
    (STATUS_VALUES < STATUS_CODES_N) ? STATUS_VALUES : STATUS_CODES_N;
  localparam int unsigned NG    = FLAG_USED * STAT_USED;
  localparam int unsigned IDX_W = (NG > 1) ? $clog2(NG) : 1;

  typedef enum logic [1:0] {
    ST_RUN    = 2'b01,
    ST_REPORT = 2'b10
  } back_state_e;

  typedef struct packed {
    logic             counted;
    logic             last;
    logic [GRP_W-1:0] grp;
    logic [15:0]      quantity;
    logic [23:0]      price;
    logic [DP_W-1:0]  discounted;
    logic [6:0]       discount;
    logic [CH_W-1:0]  charge;
  } stage_t;

  back_state_e      state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             b_valid_q, b_valid_d;
  stage_t           b_q;
  acc_t             acc_q [NG];
  logic             out_valid_q, out_valid_d;
  result_t          out_q;
  logic [NG-1:0]    nonempty;
  logic             later;
  logic             cur_ne;
  logic             out_free;
  logic             step;
  logic             load_out;
  logic             done;
  logic             b_load;
  logic             accumulate;

  // Take the next command whenever the stage register is free or drains
  assign b_load     = !cmd_empty_i && (!b_valid_q || state_q == ST_RUN);
  assign cmd_pop_o  = b_load;
  assign accumulate = (state_q == ST_RUN) && b_valid_q && b_q.counted;

  always_comb begin
    if (b_load) begin
      b_valid_d = 1'b1;
    end else if (state_q == ST_RUN) begin
      b_valid_d = 1'b0;
    end else begin
      b_valid_d = b_valid_q;
    end
  end

  // Register the command and its charge product
  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_q.counted    <= cmd_i.counted;
      b_q.last       <= cmd_i.last;
      b_q.grp        <= cmd_i.grp;
      b_q.quantity   <= cmd_i.quantity;
      b_q.price      <= cmd_i.price;
      b_q.discounted <= cmd_i.discounted;
      b_q.discount   <= cmd_i.discount;
      b_q.charge     <= {8'b0, cmd_i.discounted} * {31'b0, {1'b0, PCT} + {1'b0, cmd_i.tax}};
    end
  end

  // Report scan: flag which groups hold rows and whether any follow
  always_comb begin
    later = 1'b0;
    for (int g = 0; g < NG; g++) begin
      nonempty[g] = (acc_q[g].count != '0);
      if (g > int'(idx_q) && nonempty[g]) begin
        later = 1'b1;
      end
    end
  end

  assign cur_ne   = nonempty[idx_q];
  assign out_free = !out_valid_q || pop_i;
  assign step     = (state_q == ST_REPORT) && (!cur_ne || out_free);
  assign load_out = (state_q == ST_REPORT) && cur_ne && out_free;
  assign done     = step && (idx_q == IDX_W'(NG - 1));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_RUN: begin
        if (b_valid_q && b_q.last) begin
          state_d = ST_REPORT;
          idx_d   = '0;
        end
      end
      ST_REPORT: begin
        if (done) begin
          state_d = ST_RUN;
          idx_d   = '0;
        end else if (step) begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_RUN;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      idx_q       <= '0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Accumulate each group in its own lane; clear all at the end of a report
  for (genvar g = 0; g < NG; g++) begin : g_lane
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_q[g] <= '0;
      end else if (done) begin
        acc_q[g] <= '0;
      end else if (accumulate && b_q.grp == GRP_W'(g)) begin
        acc_q[g].quantity   <= sat_add(acc_q[g].quantity, SUM_W'(b_q.quantity));
        acc_q[g].price      <= sat_add(acc_q[g].price, SUM_W'(b_q.price));
        acc_q[g].discounted <= sat_add(acc_q[g].discounted, SUM_W'(b_q.discounted));
        acc_q[g].charge     <= sat_add(acc_q[g].charge, SUM_W'(b_q.charge));
        acc_q[g].discount   <= sat_add(acc_q[g].discount, SUM_W'(b_q.discount));
        acc_q[g].count      <= sat_add(acc_q[g].count, SUM_W'(1'b1));
      end
    end
  end

  // Hold the result until transfer; refill from the scan
  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.group_flag       <= FLAG_CODES[2'(idx_q / STAT_USED)];
      out_q.group_status     <= STATUS_CODES[1'(idx_q % STAT_USED)];
      out_q.total_quantity   <= acc_q[idx_q].quantity;
      out_q.total_price      <= acc_q[idx_q].price;
      out_q.total_discounted <= acc_q[idx_q].discounted;
      out_q.total_charge     <= acc_q[idx_q].charge;
      out_q.total_discount   <= acc_q[idx_q].discount;
      out_q.row_count        <= acc_q[idx_q].count;
      out_q.final_group      <= !later;
    end
  end

  assign result_o = out_q;
  assign empty_o  = !out_valid_q;

endmodule

@@ rtl/core/pricing_summary_group_aggregate_unit.sv @@
// Pricing summary aggregator: takes one order-line row per cycle while the queue
// has room and adds each row shipped on or before the cutoff day into its (return
// flag, line status) group. The front classifies a row and forms the discounted
// price, a command queue of FIFO_DEPTH entries carries it to the back, which
// registers it with its charge in the stage register, then adds it into its
// group's accumulator lane. A row marked last starts a report: the back scans the
// FLAG_VALUES x STATUS_VALUES groups (at most six) one per cycle, presenting each
// non-empty group on the result port and waiting while it is not popped, then
// clears the store. During the scan the back accumulates no rows and holds at most
// one in its stage, so the input stays open only while the queue has room; after
// it, one row per cycle resumes.
module pricing_summary_group_aggregate_unit #(
  parameter int unsigned FLAG_VALUES   = psga_pkg::FLAG_VALUES_DEF,
  parameter int unsigned STATUS_VALUES = psga_pkg::STATUS_VALUES_DEF,
  parameter int unsigned FIFO_DEPTH    = psga_pkg::FIFO_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  psga_pkg::row_t    row_i,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  output logic              empty,
  input  logic              pop,
  output psga_pkg::result_t result_o
);
  import psga_pkg::*;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic front_push;
  logic queue_empty;
  logic queue_pop;

  // Classify rows
  psga_front #(
    .FLAG_VALUES   (FLAG_VALUES),
    .STATUS_VALUES (STATUS_VALUES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_i       (row_i),
    .push_i      (push),
    .full_i      (full),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (front_cmd),
    .cmd_push_o  (front_push)
  );

  // Decouple front and back
  psga_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (queue_pop),
    .data_o  (queue_cmd),
    .empty_o (queue_empty)
  );

  // Accumulate and report
  psga_back #(
    .FLAG_VALUES   (FLAG_VALUES),
    .STATUS_VALUES (STATUS_VALUES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_empty_i (queue_empty),
    .cmd_pop_o   (queue_pop),
    .result_o    (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

@@ rtl/core/psga_checker.sv @@
`include "assert_macros.svh"

module psga_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input psga_pkg::result_t result_o
);
  import psga_pkg::*;

  logic codes_ok;

  // Reported codes come from the code lists
  assign codes_ok = (result_o.group_flag == FLAG_CODES[0] ||
                     result_o.group_flag == FLAG_CODES[1] ||
                     result_o.group_flag == FLAG_CODES[2]) &&
                    (result_o.group_status == STATUS_CODES[0] ||
                     result_o.group_status == STATUS_CODES[1]);

  // A waiting result holds until its transfer
  `ASSERT_NEXT(a_result_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(result_o))

  // Only groups with rows are reported
  `ASSERT_ALWAYS(a_count_nonzero, clk_i, rst_ni, empty || result_o.row_count != '0)

  `ASSERT_ALWAYS(a_codes_legal, clk_i, rst_ni, empty || codes_ok)

  // Without an input transfer the queue cannot fill up
  `ASSERT_NEXT(a_full_needs_push, clk_i, rst_ni, !full && !push, !full)

endmodule

bind pricing_summary_group_aggregate_unit psga_checker u_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  import psga_pkg::*;

  localparam int unsigned N_FLAGS    = FLAG_VALUES_DEF;
  localparam int unsigned N_STATUSES = STATUS_VALUES_DEF;
  localparam int unsigned N_GROUPS   = N_FLAGS * N_STATUSES;

  localparam logic [7:0] FLAG_A   = FLAG_CODES[0];
  localparam logic [7:0] FLAG_N   = FLAG_CODES[1];
  localparam logic [7:0] FLAG_R   = FLAG_CODES[2];
  localparam logic [7:0] STATUS_F = STATUS_CODES[0];
  localparam logic [7:0] STATUS_O = STATUS_CODES[1];

  localparam logic [63:0] SUM_TOP  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PERCENT  = 64'd100;

  localparam int DIRECTED_ROWS = 19;
  localparam int SEGMENTS      = 6;
  localparam int SEG_ROWS      = 24;
  // queue depth, three back-end stages and a six-group scan, with margin
  localparam int DRAIN_CYCLES  = 40;
  localparam int LONG_HOLD     = 80;

  typedef struct {
    logic [63:0] quantity;
    logic [63:0] price;
    logic [63:0] discounted;
    logic [63:0] charge;
    logic [63:0] discount;
    logic [63:0] count;
  } group_sums_t;

  typedef struct packed {
    row_t    row;
    logic    typed;
    result_t want;
  } dir_entry_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  row_t        row;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        empty;
  logic        pop;
  result_t     result;

  // predictor state
  group_sums_t group_sums [N_GROUPS];
  logic [15:0] cutoff_now;
  result_t     expected_groups [$];

  dir_entry_t  directed_rows [DIRECTED_ROWS];

  int push_idle_pct;
  int pop_idle_pct;
  int hold_reqs;
  int errors;
  int rows_sent;
  int rows_counted;
  int reports;
  int results_checked;
  int input_stalls;
  int cutoff_writes;

  pricing_summary_group_aggregate_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .row_i       (row),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("pricing_summary_group_aggregate_unit regression: fail");
    $finish;
  end

  function automatic row_t mk_row(logic [7:0] flag, logic [7:0] status, logic [15:0] day,
                                  logic [15:0] qty, logic [23:0] price, logic [6:0] disc,
                                  logic [6:0] tax, logic last);
    row_t r;
    r.return_flag    = flag;
    r.line_status    = status;
    r.ship_day       = day;
    r.quantity       = qty;
    r.extended_price = price;
    r.discount       = disc;
    r.tax            = tax;
    r.last_row       = last;
    return r;
  endfunction

  function automatic result_t mk_group(logic [7:0] flag, logic [7:0] status,
                                       logic [62:0] qty, logic [62:0] price,
                                       logic [62:0] discounted, logic [62:0] charge,
                                       logic [62:0] disc, logic [62:0] cnt, logic fin);
    result_t g;
    g.group_flag       = flag;
    g.group_status     = status;
    g.total_quantity   = qty;
    g.total_price      = price;
    g.total_discounted = discounted;
    g.total_charge     = charge;
    g.total_discount   = disc;
    g.row_count        = cnt;
    g.final_group      = fin;
    return g;
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s >= SUM_TOP) ? SUM_TOP : s;
  endfunction

  function automatic void clear_sums();
    int g;
    for (g = 0; g < N_GROUPS; g++) begin
      group_sums[g] = '{default: 64'd0};
    end
  endfunction

  // Fold one row into its group; on a last row queue the report and clear
  function automatic int aggregate_row(row_t r);
    int          fi;
    int          si;
    int          g;
    int          n;
    logic [63:0] disc;
    logic [63:0] dp;
    logic [63:0] ch;
    result_t     rep;
    fi = -1;
    si = -1;
    n  = 0;
    for (g = 0; g < N_FLAGS && g < FLAG_CODES_N; g++) begin
      if (fi < 0 && FLAG_CODES[g] == r.return_flag) fi = g;
    end
    for (g = 0; g < N_STATUSES && g < STATUS_CODES_N; g++) begin
      if (si < 0 && STATUS_CODES[g] == r.line_status) si = g;
    end
    // clamp the discount at a hundred per cent
    disc = (r.discount > 7'd100) ? PERCENT : {57'd0, r.discount};
    if (fi >= 0 && si >= 0 && r.ship_day <= cutoff_now) begin
      dp = {40'd0, r.extended_price} * (PERCENT - disc);
      ch = dp * (PERCENT + {57'd0, r.tax});
      g  = fi * N_STATUSES + si;
      group_sums[g].quantity   = sat_sum(group_sums[g].quantity, {48'd0, r.quantity});
      group_sums[g].price      = sat_sum(group_sums[g].price, {40'd0, r.extended_price});
      group_sums[g].discounted = sat_sum(group_sums[g].discounted, dp);
      group_sums[g].charge     = sat_sum(group_sums[g].charge, ch);
      group_sums[g].discount   = sat_sum(group_sums[g].discount, disc);
      group_sums[g].count      = sat_sum(group_sums[g].count, 64'd1);
      rows_counted++;
    end
    if (!r.last_row) return 0;
    reports++;
    for (g = 0; g < N_GROUPS; g++) begin
      if (group_sums[g].count != 0 && g / N_STATUSES < FLAG_CODES_N &&
          g % N_STATUSES < STATUS_CODES_N) begin
        rep = mk_group(FLAG_CODES[g / N_STATUSES], STATUS_CODES[g % N_STATUSES],
                       group_sums[g].quantity[62:0], group_sums[g].price[62:0],
                       group_sums[g].discounted[62:0], group_sums[g].charge[62:0],
                       group_sums[g].discount[62:0], group_sums[g].count[62:0], 1'b0);
        expected_groups.insert(expected_groups.size(), rep);
        n++;
      end
    end
    if (n > 0) expected_groups[expected_groups.size() - 1].final_group = 1'b1;
    clear_sums();
    return n;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                              results_checked, name, got, want));
    end
  endtask

  task automatic check_group(input result_t got);
    result_t want;
    if (expected_groups.size() == 0) begin
      flag_mismatch($sformatf("group %02h/%02h arrived with nothing expected",
                              got.group_flag, got.group_status));
      return;
    end
    want = expected_groups.pop_front();
    compare_field("group_flag", 64'(got.group_flag), 64'(want.group_flag));
    compare_field("group_status", 64'(got.group_status), 64'(want.group_status));
    compare_field("total_quantity", 64'(got.total_quantity), 64'(want.total_quantity));
    compare_field("total_price", 64'(got.total_price), 64'(want.total_price));
    compare_field("total_discounted", 64'(got.total_discounted),
                  64'(want.total_discounted));
    compare_field("total_charge", 64'(got.total_charge), 64'(want.total_charge));
    compare_field("total_discount", 64'(got.total_discount), 64'(want.total_discount));
    compare_field("row_count", 64'(got.row_count), 64'(want.row_count));
    compare_field("final_group", 64'(got.final_group), 64'(want.final_group));
    results_checked++;
  endtask

  // Offer one row, idling at random first; predict once the transfer happens
  task automatic offer_row(input row_t r, input logic typed = 1'b0,
                           input result_t want = '0);
    int n;
    while ($urandom_range(99) < push_idle_pct) begin
      @(negedge clk);
      push = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    push = 1'b1;
    row  = r;
    @(posedge clk);
    while (full) begin
      input_stalls++;
      @(posedge clk);
    end
    rows_sent++;
    n = aggregate_row(r);
    // replace the prediction by the hand-written group where one is given
    if (typed) begin
      repeat (n) void'(expected_groups.pop_back());
      expected_groups.insert(expected_groups.size(), want);
    end
  endtask

  // Drain the block, let the back end settle, then write the cutoff
  task automatic program_cutoff(input logic [15:0] value);
    @(negedge clk);
    push = 1'b0;
    while (expected_groups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we     = 1'b1;
    cfg_wdata  = value;
    cutoff_now = value;
    @(negedge clk);
    cfg_we = 1'b0;
    cutoff_writes++;
  endtask

  function automatic row_t random_row();
    row_t r;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 85) begin
      r.return_flag = FLAG_CODES[$urandom_range(FLAG_CODES_N - 1)];
      r.line_status = STATUS_CODES[$urandom_range(STATUS_CODES_N - 1)];
    end else begin
      r.return_flag = 8'($urandom);
      r.line_status = 8'($urandom);
    end
    pick = $urandom_range(19);
    if (pick < 12)      r.ship_day = 16'($urandom_range(int'(cutoff_now)));
    else if (pick < 15) r.ship_day = cutoff_now + 16'd1;
    else if (pick < 17) r.ship_day = 16'd0;
    else if (pick < 18) r.ship_day = 16'hFFFF;
    else                r.ship_day = 16'($urandom);
    r.quantity       = 16'($urandom);
    r.extended_price = ($urandom_range(9) == 0) ? 24'hFF_FFFF : 24'($urandom);
    r.discount       = ($urandom_range(4) == 0) ? 7'($urandom) : 7'($urandom_range(100));
    r.tax            = ($urandom_range(4) == 0) ? 7'($urandom) : 7'($urandom_range(100));
    r.last_row       = ($urandom_range(7) == 0);
    return r;
  endfunction

  // Result side: random or held-off pop, check at the rising edge
  initial begin : result_side
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    pop        = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_seen) begin
        hold_left  = LONG_HOLD;
        holds_seen = hold_reqs;
      end
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        pop = ($urandom_range(99) >= pop_idle_pct);
      end
      @(posedge clk);
      if (pop && !empty) check_group(result);
    end
  end

  // Stimulus
  initial begin : row_side
    int          i;
    int          seg;
    logic [15:0] cutoff_plan [SEGMENTS];
    row_t        r;

    rst_n           = 1'b0;
    push            = 1'b0;
    row             = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    hold_reqs       = 0;
    errors          = 0;
    rows_sent       = 0;
    rows_counted    = 0;
    reports         = 0;
    results_checked = 0;
    input_stalls    = 0;
    cutoff_writes   = 0;
    cutoff_now      = CUTOFF_RESET;
    clear_sums();

    // Bytes such as 8'h61, 8'h58, 8'hFF and 8'h00 below are deliberately not codes
    directed_rows = '{
      // smallest row forms a one-row group
      '{mk_row(FLAG_A, STATUS_F, 16'd0, 16'd0, 24'd0, 7'd0, 7'd0, 1'b1), 1'b1,
        mk_group(FLAG_A, STATUS_F, 63'd0, 63'd0, 63'd0, 63'd0, 63'd0, 63'd1, 1'b1)},
      // largest quantity and price, highest tax, shipped on the cutoff day
      '{mk_row(FLAG_R, STATUS_O, 16'd10471, 16'hFFFF, 24'hFF_FFFF, 7'd0, 7'd127, 1'b1),
        1'b1, mk_group(FLAG_R, STATUS_O, 63'd65535, 63'd16777215, 63'd1677721500,
                       63'd380842780500, 63'd0, 63'd1, 1'b1)},
      // shipped a day late: dropped, report is empty
      '{mk_row(FLAG_N, STATUS_F, 16'd10472, 16'd1, 24'd1, 7'd1, 7'd1, 1'b1), 1'b0, '0},
      // discount over a hundred zeroes the discounted price and charge
      '{mk_row(FLAG_A, STATUS_O, 16'd100, 16'd100, 24'd1000, 7'd127, 7'd5, 1'b1), 1'b1,
        mk_group(FLAG_A, STATUS_O, 63'd100, 63'd1000, 63'd0, 63'd0, 63'd100, 63'd1, 1'b1)},
      // unknown flag, unknown status, then an unknown pair carrying the last mark
      '{mk_row(8'h61, STATUS_F, 16'd5, 16'd7, 24'd70, 7'd3, 7'd4, 1'b0), 1'b0, '0},
      '{mk_row(FLAG_N, 8'h58, 16'd5, 16'd7, 24'd70, 7'd3, 7'd4, 1'b0), 1'b0, '0},
      '{mk_row(8'hFF, 8'h00, 16'd0, 16'd9, 24'd90, 7'd9, 7'd9, 1'b1), 1'b0, '0},
      // one row into each of the six groups, the last of them closes the report
      '{mk_row(FLAG_A, STATUS_F, 16'd1, 16'd150, 24'd12345, 7'd4, 7'd2, 1'b0), 1'b0, '0},
      '{mk_row(FLAG_A, STATUS_O, 16'd2, 16'd250, 24'd54321, 7'd100, 7'd8, 1'b0), 1'b0, '0},
      '{mk_row(FLAG_N, STATUS_F, 16'd3, 16'd350, 24'd99999, 7'd10, 7'd100, 1'b0), 1'b0, '0},
      '{mk_row(FLAG_N, STATUS_O, 16'd4, 16'd450, 24'hAA_AAAA, 7'd7, 7'd0, 1'b0), 1'b0, '0},
      '{mk_row(FLAG_R, STATUS_F, 16'd5, 16'd550, 24'h55_5555, 7'd0, 7'd6, 1'b0), 1'b0, '0},
      '{mk_row(FLAG_R, STATUS_O, 16'd10471, 16'd650, 24'd1, 7'd64, 7'd64, 1'b1), 1'b0, '0},
      // latest ship day is beyond the reset cutoff
      '{mk_row(FLAG_N, STATUS_O, 16'hFFFF, 16'd1, 24'd1, 7'd1, 7'd1, 1'b0), 1'b0, '0},
      '{mk_row(FLAG_R, STATUS_F, 16'd10471, 16'hFFFF, 24'hFF_FFFF, 7'd50, 7'd100, 1'b0),
        1'b0, '0},
      '{mk_row(FLAG_R, STATUS_F, 16'd1, 16'd2, 24'd3, 7'd101, 7'd0, 1'b0), 1'b0, '0},
      '{mk_row(8'h00, 8'hFF, 16'd0, 16'd0, 24'd0, 7'd0, 7'd0, 1'b1), 1'b0, '0},
      // two largest rows summed into one group
      '{mk_row(FLAG_A, STATUS_F, 16'd10471, 16'hFFFF, 24'hFF_FFFF, 7'd0, 7'd0, 1'b0),
        1'b0, '0},
      '{mk_row(FLAG_A, STATUS_F, 16'd10471, 16'hFFFF, 24'hFF_FFFF, 7'd0, 7'd0, 1'b1),
        1'b0, '0}
    };

    cutoff_plan = '{16'hFFFF, 16'h0000, 16'($urandom), CUTOFF_RESET,
                    16'($urandom), 16'hFFFF};

    push_idle_pct = 32;
    pop_idle_pct  = 79;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows at the reset cutoff
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      offer_row(directed_rows[i].row, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random segments, each under its own cutoff, with an idling pattern per pair of segments
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0:       begin push_idle_pct = 32; pop_idle_pct = 79; end
        1:       begin push_idle_pct = 79; pop_idle_pct = 32; end
        default: begin push_idle_pct = 0;  pop_idle_pct = 0;  end
      endcase
      program_cutoff(cutoff_plan[seg]);
      // hold off the receiver so the scan stalls and the queue fills
      if (seg == SEGMENTS - 1) hold_reqs++;
      for (i = 0; i < SEG_ROWS; i++) begin
        r = random_row();
        if (i == SEG_ROWS - 1 || (seg == SEGMENTS - 1 && i == 3)) r.last_row = 1'b1;
        offer_row(r);
      end
    end

    @(negedge clk);
    push = 1'b0;
    while (expected_groups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d rows (%0d counted), %0d reports, %0d group results checked",
             rows_sent, rows_counted, reports, results_checked);
    $display("%0d cutoff writes, %0d input stall cycles, %0d mismatches",
             cutoff_writes, input_stalls, errors);
    if (errors == 0) begin
      $display("pricing_summary_group_aggregate_unit regression: pass");
    end else begin
      $display("pricing_summary_group_aggregate_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/psga_pkg.sv
rtl/core/psga_front.sv
rtl/core/psga_fifo.sv
rtl/core/psga_back.sv
rtl/core/pricing_summary_group_aggregate_unit.sv
rtl/core/psga_checker.sv
tb/testbench.sv
